/* hdl/bet_pkg.sv */
// ----------------------------------------------------------------------------
// bet_pkg
// Shared types, constants and character helpers for the expression tokenizer.
// ----------------------------------------------------------------------------
package bet_pkg;

    // Width of the position and length counters inside the block.
    localparam int POS_BITS = 16;

    // Width of the offset and length fields of a result.
    localparam int FIELD_BITS = 16;

    // Result queue depth and its pointer width.
    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = $clog2(RQ_DEPTH);
    localparam int RQ_CNT_W = $clog2(RQ_DEPTH + 1);

    // Characters of the special identifier LOOP.
    localparam logic [7:0] LOOP_WORD [4] = '{8'h4C, 8'h4F, 8'h4F, 8'h50};

    // Value of loop_match once the identifier can no longer be LOOP.
    localparam logic [2:0] LOOP_BROKEN = 3'd5;
    localparam logic [2:0] LOOP_FULL   = 3'd4;

    // Named characters.
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_LPAR    = 8'h28;
    localparam logic [7:0] CH_RPAR    = 8'h29;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;

    // Scanner modes.
    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_IDENT  = 3'd1,
        MODE_NUMBER = 3'd2,
        MODE_OPER   = 3'd3,
        MODE_ERROR  = 3'd4
    } mode_t;

    // Token kinds.
    typedef enum logic [4:0] {
        K_IDENT   = 5'd0,
        K_NUMBER  = 5'd1,
        K_GE      = 5'd2,
        K_GT      = 5'd3,
        K_LE      = 5'd4,
        K_LT      = 5'd5,
        K_NE      = 5'd6,
        K_EQ      = 5'd7,
        K_ASSIGN  = 5'd8,
        K_ADD     = 5'd9,
        K_SUB     = 5'd10,
        K_MUL     = 5'd11,
        K_DIV     = 5'd12,
        K_POW     = 5'd13,
        K_LPAR    = 5'd14,
        K_RPAR    = 5'd15,
        K_COMMA   = 5'd16,
        K_NEWLINE = 5'd17,
        K_ERROR   = 5'd18
    } kind_t;

    // Scanner state carried from one character to the next.
    typedef struct packed {
        mode_t                 mode;
        logic [POS_BITS-1:0]   position;
        logic [POS_BITS-1:0]   pend_start;
        logic [POS_BITS-1:0]   pend_len;
        logic [2:0]            loop_match;
        logic [7:0]            op_a;
        logic [7:0]            op_b;
        logic [1:0]            op_count;
    } scan_state_t;

    // One result as it travels to the output.
    typedef struct packed {
        kind_t                  kind;
        logic [FIELD_BITS-1:0]  start;
        logic [FIELD_BITS-1:0]  length;
        logic                   last;
    } result_t;

    // Results produced by one character: up to two, in order.
    typedef struct packed {
        logic [1:0] count;
        result_t    res1;
        result_t    res0;
    } scan_out_t;

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_op_start(input logic [7:0] c);
        return (c == CH_GT) || (c == CH_LT) || (c == CH_EQ) || (c == CH_PLUS) ||
               (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH) || (c == CH_CARET);
    endfunction

    // Saturating increment of a counter.
    function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
        return (v == {POS_BITS{1'b1}}) ? v : v + 1'b1;
    endfunction

    // Low bits of a counter as a result field, zero-extended when narrower.
    function automatic logic [FIELD_BITS-1:0] to_field(input logic [POS_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[FIELD_BITS-1:0];
    endfunction

    // Kind of a pending operator, or an error for an unknown spelling.
    function automatic kind_t oper_kind(input logic [7:0] a, input logic [7:0] b,
                                        input logic [1:0] cnt);
        kind_t k;
        k = K_ERROR;
        if (cnt == 2'd1) begin
            case (a)
                CH_GT:    k = K_GT;
                CH_LT:    k = K_LT;
                CH_EQ:    k = K_ASSIGN;
                CH_PLUS:  k = K_ADD;
                CH_MINUS: k = K_SUB;
                CH_STAR:  k = K_MUL;
                CH_SLASH: k = K_DIV;
                CH_CARET: k = K_POW;
                default:  k = K_ERROR;
            endcase
        end else if (cnt == 2'd2) begin
            if ((a == CH_GT) && (b == CH_EQ)) begin
                k = K_GE;
            end else if ((a == CH_LT) && (b == CH_EQ)) begin
                k = K_LE;
            end else if ((a == CH_LT) && (b == CH_GT)) begin
                k = K_NE;
            end else if ((a == CH_EQ) && (b == CH_EQ)) begin
                k = K_EQ;
            end
        end
        return k;
    endfunction

endpackage

/* hdl/bet_scan.sv */
// ----------------------------------------------------------------------------
// bet_scan
// Combinational step of the tokenizer: next scanner state and the results
// that one character causes.
// ----------------------------------------------------------------------------
module bet_scan (
    input  bet_pkg::scan_state_t cur,
    input  logic [7:0]           ch,
    input  logic                 end_of_source,
    output bet_pkg::scan_state_t nxt,
    output bet_pkg::scan_out_t   results
);
    import bet_pkg::*;

    always_comb
    begin
        scan_state_t         s;
        result_t             res [2];
        logic [1:0]          n;
        logic [POS_BITS-1:0] at;
        logic                closing;
        logic                do_fresh;
        logic                alnum;
        kind_t               ck;
        kind_t               fk;
        logic                f_emit;

        s        = cur;
        res[0]   = '0;
        res[1]   = '0;
        n        = 2'd0;
        at       = cur.position;
        closing  = 1'b0;
        do_fresh = 1'b0;
        alnum    = is_letter(ch) || is_digit(ch);
        ck       = K_ERROR;
        fk       = K_ERROR;
        f_emit   = 1'b0;

        s.position = sat_inc(cur.position);

        // Extend the open token or decide to close it.
        case (cur.mode)
            MODE_IDENT:
            begin
                if (alnum) begin
                    s.pend_len = sat_inc(cur.pend_len);
                    if ((cur.loop_match < LOOP_FULL) &&
                        (ch == LOOP_WORD[cur.loop_match[1:0]])) begin
                        s.loop_match = cur.loop_match + 3'd1;
                    end else begin
                        s.loop_match = LOOP_BROKEN;
                    end
                end else if (cur.loop_match == LOOP_FULL) begin
                    // An open LOOP swallows any character that is not a letter or digit.
                    s.pend_len = sat_inc(cur.pend_len);
                end else begin
                    closing  = 1'b1;
                    do_fresh = 1'b1;
                end
            end
            MODE_NUMBER:
            begin
                if (is_digit(ch) || (ch == CH_DOT)) begin
                    s.pend_len = sat_inc(cur.pend_len);
                end else begin
                    closing  = 1'b1;
                    do_fresh = 1'b1;
                end
            end
            MODE_OPER:
            begin
                if ((ch == CH_EQ) || (ch == CH_GT)) begin
                    s.pend_len = sat_inc(cur.pend_len);
                    if (cur.op_count == 2'd1) begin
                        s.op_b = ch;
                    end
                    if (cur.op_count != 2'd3) begin
                        s.op_count = cur.op_count + 2'd1;
                    end
                end else begin
                    closing  = 1'b1;
                    // A bad operator also drops the character that closed it.
                    do_fresh = (oper_kind(cur.op_a, cur.op_b, cur.op_count) != K_ERROR);
                end
            end
            MODE_IDLE:
            begin
                do_fresh = 1'b1;
            end
            default:
            begin
                do_fresh = 1'b0;
            end
        endcase

        // Report the token being closed.
        if (closing) begin
            if (cur.mode == MODE_IDENT) begin
                ck = K_IDENT;
            end else if (cur.mode == MODE_NUMBER) begin
                ck = K_NUMBER;
            end else begin
                ck = oper_kind(cur.op_a, cur.op_b, cur.op_count);
            end
            res[0].kind   = ck;
            res[0].start  = to_field(cur.pend_start);
            res[0].length = to_field(cur.pend_len);
            n             = 2'd1;
            s.mode        = (ck == K_ERROR) ? MODE_ERROR : MODE_IDLE;
        end

        // Start something new with this character.
        if (do_fresh) begin
            s.pend_start = at;
            s.pend_len   = {{(POS_BITS-1){1'b0}}, 1'b1};
            if (is_letter(ch)) begin
                s.mode       = MODE_IDENT;
                s.loop_match = (ch == LOOP_WORD[0]) ? 3'd1 : LOOP_BROKEN;
            end else if (is_digit(ch)) begin
                s.mode = MODE_NUMBER;
            end else if (is_op_start(ch)) begin
                s.mode     = MODE_OPER;
                s.op_a     = ch;
                s.op_b     = 8'h00;
                s.op_count = 2'd1;
            end else if (ch == CH_LPAR) begin
                fk     = K_LPAR;
                f_emit = 1'b1;
            end else if (ch == CH_RPAR) begin
                fk     = K_RPAR;
                f_emit = 1'b1;
            end else if (ch == CH_COMMA) begin
                fk     = K_COMMA;
                f_emit = 1'b1;
            end else if (ch == CH_NEWLINE) begin
                fk     = K_NEWLINE;
                f_emit = 1'b1;
            end else if ((ch == CH_SPACE) || (ch == CH_TAB)) begin
                f_emit = 1'b0;
            end else begin
                fk     = K_ERROR;
                f_emit = 1'b1;
                s.mode = MODE_ERROR;
            end
            if (f_emit) begin
                res[n[0]].kind   = fk;
                res[n[0]].start  = to_field(at);
                res[n[0]].length = {{(FIELD_BITS-1){1'b0}}, 1'b1};
                n                = n + 2'd1;
            end
        end

        // End of source closes any open token and returns to the reset state.
        if (end_of_source) begin
            if ((s.mode == MODE_IDENT) || (s.mode == MODE_NUMBER) ||
                (s.mode == MODE_OPER)) begin
                if (s.mode == MODE_IDENT) begin
                    ck = K_IDENT;
                end else if (s.mode == MODE_NUMBER) begin
                    ck = K_NUMBER;
                end else begin
                    ck = oper_kind(s.op_a, s.op_b, s.op_count);
                end
                res[n[0]].kind   = ck;
                res[n[0]].start  = to_field(s.pend_start);
                res[n[0]].length = to_field(s.pend_len);
                n                = n + 2'd1;
            end
            s = '0;
        end

        // Mark the final result of this character.
        if (n == 2'd1) begin
            res[0].last = 1'b1;
        end else if (n == 2'd2) begin
            res[1].last = 1'b1;
        end

        nxt           = s;
        results.count = n;
        results.res0  = res[0];
        results.res1  = res[1];
    end

endmodule

/* hdl/bet_rqueue.sv */
// ----------------------------------------------------------------------------
// bet_rqueue
// Small result queue: takes up to two results per cycle and hands them out
// one per request on the output channel.
// ----------------------------------------------------------------------------
module bet_rqueue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  bet_pkg::scan_out_t  push_data,
    output logic                room,
    output logic                out_valid,
    input  logic                out_ready,
    output bet_pkg::result_t    head
);
    import bet_pkg::*;

    result_t               entry_reg [RQ_DEPTH];
    logic [RQ_PTR_W-1:0]   wr_ptr_reg;
    logic [RQ_PTR_W-1:0]   wr_ptr_next;
    logic [RQ_PTR_W-1:0]   rd_ptr_reg;
    logic [RQ_PTR_W-1:0]   rd_ptr_next;
    logic [RQ_CNT_W-1:0]   count_reg;
    logic [RQ_CNT_W-1:0]   count_next;
    logic [RQ_CNT_W-1:0]   push_n;
    logic                  pop;

    // Room for the worst case of two results from one character.
    assign room      = (count_reg <= RQ_CNT_W'(RQ_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign push_n    = push ? RQ_CNT_W'(push_data.count) : '0;

    // Pointer and fill count bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + RQ_PTR_W'(push_n);
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + push_n - RQ_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Result storage; no reset needed on payload.
    always_ff @(posedge clk)
    begin
        if (push && (push_data.count != 2'd0)) begin
            entry_reg[wr_ptr_reg] <= push_data.res0;
        end
        if (push && (push_data.count == 2'd2)) begin
            entry_reg[wr_ptr_reg + 1'b1] <= push_data.res1;
        end
    end

endmodule

/* hdl/basic_expression_tokenizer_core.sv */
// ----------------------------------------------------------------------------
// basic_expression_tokenizer_core
// Streaming tokenizer: one source character per request in, tokens with
// kind, start offset and length out.
// ----------------------------------------------------------------------------
//  Channel | Handshake             | Payload
//  --------+-----------------------+----------------------------------------
//  input   | in_valid / in_ready   | ch, end_of_source
//  output  | out_valid / out_ready | token_kind, token_start, token_length,
//          |                       | last_in_run
//
// One character is taken per cycle while the queue has room; it is held in an
// input register and scanned once the queue can take its results, which are
// then written into the queue. Each character yields zero to two results,
// which wait in a four-entry queue; the input stalls only while that queue
// has fewer than two free entries. Reset clears the scanner and the queue.
// ----------------------------------------------------------------------------
module basic_expression_tokenizer_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       ch,
    input  logic                             end_of_source,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [4:0]                       token_kind,
    output logic [bet_pkg::FIELD_BITS-1:0]   token_start,
    output logic [bet_pkg::FIELD_BITS-1:0]   token_length,
    output logic                             last_in_run
);
    import bet_pkg::*;

    logic        in_vld_reg;
    logic [7:0]  ch_reg;
    logic        eos_reg;
    scan_state_t state_reg;
    scan_state_t state_next;
    scan_out_t   scan_res;
    logic        room;
    logic        fire;
    result_t     head;

    // The held character is scanned when the queue can take its results.
    assign fire     = in_vld_reg && room;
    assign in_ready = !in_vld_reg || fire;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_vld_reg <= 1'b0;
        end else if (in_valid && in_ready) begin
            in_vld_reg <= 1'b1;
        end else if (fire) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            ch_reg  <= ch;
            eos_reg <= end_of_source;
        end
    end

    // Scanner state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= '0;
        end else if (fire) begin
            state_reg <= state_next;
        end
    end

    bet_scan u_scan (
        .cur           (state_reg),
        .ch            (ch_reg),
        .end_of_source (eos_reg),
        .nxt           (state_next),
        .results       (scan_res)
    );

    bet_rqueue u_rqueue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fire),
        .push_data (scan_res),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    // Output fields come straight from the queue head.
    assign token_kind   = head.kind;
    assign token_start  = head.start;
    assign token_length = head.length;
    assign last_in_run  = head.last;

endmodule

/* hdl/bet_checker.sv */
// ----------------------------------------------------------------------------
// bet_checker
// Port-level checks for the tokenizer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module bet_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [4:0]                       token_kind,
    input logic [bet_pkg::FIELD_BITS-1:0]   token_length
);
    import bet_pkg::*;

    // A stalled request stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output request dropped while stalled");

    // Kinds stay within the token table.
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (token_kind <= K_ERROR))
        else $error("token kind out of range");

    // Every token covers at least one character.
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (token_length != '0))
        else $error("token of zero length");

    // Punctuation and newline tokens are one character long.
    a_single_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((token_kind == K_LPAR) || (token_kind == K_RPAR) ||
                      (token_kind == K_COMMA) || (token_kind == K_NEWLINE))
        |-> (token_length == FIELD_BITS'(1)))
        else $error("single-character token with wrong length");

endmodule

bind basic_expression_tokenizer_core bet_checker u_bet_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_kind   (token_kind),
    .token_length (token_length)
);
